FILE: design/key_tag_sorter_assert.svh
// Assertion macros for the key_tag_sorter checker.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef KEY_TAG_SORTER_ASSERT_SVH
`define KEY_TAG_SORTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/kts_pkg.sv
// Shared constants, types and cell command codes for the key/tag sorter.
// No dependencies; used by kts_cell, key_tag_sorter and kts_checker.
`default_nettype none

package kts_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int KEY_BITS  = 64;
	localparam int TAG_BITS  = 16;
	localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);

	typedef logic [1:0] op_t;

	localparam op_t OP_HOLD       = 2'd0;
	localparam op_t OP_LOAD       = 2'd1;
	localparam op_t OP_SHIFT_UP   = 2'd2;
	localparam op_t OP_SHIFT_DOWN = 2'd3;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} item_t;

	typedef struct packed {
		logic occupied;
		op_t  op;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/key_tag_sorter.sv
// Top level of the key/tag sorter: insertion cell chain and drain control.
// Depends on kts_pkg and kts_cell.
`default_nettype none

// key_tag_sorter collects a batch of requests, each a 64-bit key and a 16-bit
// tag, and replays them in ascending key order; equal keys come out in arrival
// order. A request is accepted on a rising edge with start high and busy low.
// While a batch is being collected busy stays low, so one request can be taken
// every cycle: the new key is compared against every cell of a 64-cell chain
// at once and slotted in by shifting the larger keys up one cell. The request
// with batch_end set is inserted too, and then the block drains: busy goes
// high and cell 0 is shown on the result ports with done high, one result
// per cycle, while the chain shifts down one cell, until all N items held
// (1 to 64) have been shown. The receiver cannot stall; each result is valid
// for exactly that one cycle. final_item marks the last result. Requests
// arriving with all 64 cells occupied are dropped (a batch_end request still
// starts the drain) and every result of that batch shows overflowed high.
// After the drain the store is empty and the next batch may start on the
// following cycle.
module key_tag_sorter (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [kts_pkg::KEY_BITS-1:0] sort_key,
	input  wire  [kts_pkg::TAG_BITS-1:0] item_tag,
	input  wire                          batch_end,
	output logic                         done,
	output logic [kts_pkg::KEY_BITS-1:0] sorted_key,
	output logic [kts_pkg::TAG_BITS-1:0] sorted_tag,
	output logic                         final_item,
	output logic                         overflowed
);

	localparam int N = kts_pkg::MAX_ITEMS;
	localparam int CW = kts_pkg::CNT_BITS;

	logic [CW-1:0]      count_q;
	logic               drain_q;
	logic               ovf_q;

	logic               accept;
	logic               full;
	logic               ins;

	kts_pkg::item_t     ins_item;
	kts_pkg::item_t     cell_item [N];
	kts_pkg::cell_ctl_t cell_ctl  [N];
	logic [N-1:0]       gt;

	assign accept = start && !busy;
	assign full   = (count_q == CW'(N));
	assign ins    = accept && !full;

	assign ins_item.key = sort_key;
	assign ins_item.tag = item_tag;

	// Build the chain; each cell sees its neighbors' contents.
	for (genvar i = 0; i < N; i++) begin : g_cell
		kts_pkg::item_t left_item;
		kts_pkg::item_t right_item;
		logic           left_gt;

		if (i == 0) begin : g_first
			assign left_item = ins_item;
			assign left_gt   = 1'b0;
		end else begin : g_mid
			assign left_item = cell_item[i-1];
			assign left_gt   = gt[i-1];
		end

		if (i == N - 1) begin : g_last
			assign right_item = cell_item[i];
		end else begin : g_inner
			assign right_item = cell_item[i+1];
		end

		// Drain moves everything toward cell 0; insert loads the first greater
		// cell and pushes the rest up.
		always_comb begin
			cell_ctl[i].occupied = (count_q > CW'(i));
			if (drain_q) begin
				cell_ctl[i].op = kts_pkg::OP_SHIFT_DOWN;
			end else if (ins && gt[i]) begin
				cell_ctl[i].op = left_gt ? kts_pkg::OP_SHIFT_UP : kts_pkg::OP_LOAD;
			end else begin
				cell_ctl[i].op = kts_pkg::OP_HOLD;
			end
		end

		kts_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.ins_item   (ins_item),
			.left_item  (left_item),
			.right_item (right_item),
			.item       (cell_item[i]),
			.gt         (gt[i])
		);
	end

	// Fill count, drain flag and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drain_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (drain_q) begin
			// Advance one result per cycle; stop after the last one.
			count_q <= count_q - CW'(1);
			if (count_q == CW'(1)) begin
				drain_q <= 1'b0;
				ovf_q   <= 1'b0;
			end
		end else if (accept) begin
			if (ins) begin
				count_q <= count_q + CW'(1);
			end
			if (full) begin
				ovf_q <= 1'b1;
			end
			if (batch_end) begin
				drain_q <= 1'b1;
			end
		end
	end

	// Results come straight from cell 0 and the control registers.
	assign busy       = drain_q;
	assign done       = drain_q;
	assign sorted_key = cell_item[0].key;
	assign sorted_tag = cell_item[0].tag;
	assign final_item = drain_q && (count_q == CW'(1));
	assign overflowed = ovf_q;

endmodule

`default_nettype wire

FILE: design/kts_cell.sv
// One slot of the sorting chain: holds a key/tag pair and compares it to the
// incoming key. Depends on kts_pkg.
`default_nettype none

module kts_cell (
	input  wire                 clk,
	input  kts_pkg::cell_ctl_t  ctl,
	input  kts_pkg::item_t      ins_item,
	input  kts_pkg::item_t      left_item,
	input  kts_pkg::item_t      right_item,
	output kts_pkg::item_t      item,
	output logic                gt
);

	kts_pkg::item_t item_q;

	// Empty slots count as greater so the new item lands at the first one.
	assign gt   = !ctl.occupied || (item_q.key > ins_item.key);
	assign item = item_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			kts_pkg::OP_HOLD:       item_q <= item_q;
			kts_pkg::OP_LOAD:       item_q <= ins_item;
			kts_pkg::OP_SHIFT_UP:   item_q <= left_item;
			kts_pkg::OP_SHIFT_DOWN: item_q <= right_item;
			default:                item_q <= item_q;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/kts_checker.sv
// Port-level checker for key_tag_sorter and the bind that attaches it.
// Depends on key_tag_sorter_assert.svh and kts_pkg.
`default_nettype none

`include "key_tag_sorter_assert.svh"

module kts_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          start,
	input wire                          busy,
	input wire                          batch_end,
	input wire                          done,
	input wire [kts_pkg::KEY_BITS-1:0] sorted_key,
	input wire                          final_item,
	input wire                          overflowed
);

	logic accepted_end;
	logic mid_result;

	assign accepted_end = start && !busy && batch_end;
	assign mid_result   = done && !final_item;

	`KTS_ASSERT_NEXT(a_end_starts_drain, accepted_end, done, "batch end did not start results")
	`KTS_ASSERT_NEXT(a_final_ends_drain, done && final_item, !done, "results ran past final")
	`KTS_ASSERT_NEXT(a_drain_continues, mid_result, done, "results stopped before final")
	`KTS_ASSERT_NOW(a_keys_ascend, done && $past(done) && !$past(final_item), sorted_key >= $past(sorted_key), "sorted keys out of order")
	`KTS_ASSERT_NEXT(a_ovf_steady, mid_result, overflowed == $past(overflowed), "overflowed changed within a batch")

endmodule

bind key_tag_sorter kts_checker u_kts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.batch_end  (batch_end),
	.done       (done),
	.sorted_key (sorted_key),
	.final_item (final_item),
	.overflowed (overflowed)
);

`default_nettype wire
